[sv/mcpg_pkg.sv]
// Shared types, constants and codes of the midpoint circle point generator.
// No dependencies; every other file of the block imports this package.
package mcpg_pkg;

   // Field and register widths
   localparam int unsigned SIZE_W      = 10;   // plane_height, plane_width
   localparam int unsigned SCALE_W     = 8;    // radius_scale, Q4.4
   localparam int unsigned ASPECT_W    = 8;    // row_aspect, Q0.8
   localparam int unsigned RADIUS_W    = 8;
   localparam int unsigned SCALE_FRAC  = 4;
   localparam int unsigned ASPECT_FRAC = 8;
   localparam int unsigned COORD_W     = 14;   // point_row, point_col
   localparam int unsigned CALC_W      = 15;   // coordinate arithmetic before truncation
   localparam int unsigned X_W         = 12;   // step_x, unsigned
   localparam int unsigned Y_W         = 13;   // step_y, signed (holds an unwrapped radius)
   localparam int unsigned ROFF_W      = 13;   // aspect-scaled offsets
   localparam int unsigned DEC_W       = 16;   // decision term, signed
   localparam int unsigned CSR_W       = 10;
   localparam int unsigned CSR_IDX_W   = 2;

   // Midpoint recurrence constants
   localparam int unsigned DECISION_INIT = 3;
   localparam int unsigned DEC_STEP_NEG  = 6;
   localparam int unsigned DEC_STEP_POS  = 10;

   // Division of the plane height by three: floor(h * 683 / 2048) is exact for h < 1024
   localparam int unsigned DIV3_MUL   = 683;
   localparam int unsigned DIV3_SHIFT = 11;

   // Eight octant points per advance
   localparam int unsigned IDX_W    = 3;
   localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;

   // Defaults
   localparam int unsigned PLANE_MAX_DEF   = 512;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 10'd480;
   localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 10'd480;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd16;
   localparam logic [ASPECT_W-1:0] ASPECT_RESET = 8'd136;

   typedef enum logic {
      MODE_START   = 1'b0,
      MODE_ADVANCE = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLANE_HEIGHT = 2'd0,
      CSR_PLANE_WIDTH  = 2'd1,
      CSR_RADIUS_SCALE = 2'd2,
      CSR_ROW_ASPECT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      mode_type              mode;
      logic [RADIUS_W-1:0]   radius;
   } req_data_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_row;
      logic [COORD_W-1:0] point_col;
      logic               on_plane;
      logic               last_point;
      logic               circle_done;
   } rsp_data_type;

   // One advanced step, handed from the front to the back through the queue
   typedef struct packed {
      logic [X_W-1:0] step_x;
      logic [Y_W-1:0] step_y;
      logic           circle_done;
   } step_entry_type;

endpackage

[sv/mcpg_front.sv]
// Front end: takes request transactions, runs the midpoint recurrence and
// pushes each advanced step into the step queue. Depends on mcpg_pkg.
module mcpg_front
   import mcpg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_data_type         req_data,
   output logic                 req_stall,
   input  logic [SCALE_W-1:0]   radius_scale,
   input  logic                 queue_full,
   output logic                 push,
   output step_entry_type       push_entry
);

   logic [X_W-1:0]   step_x_ff,   step_x_in;
   logic [Y_W-1:0]   step_y_ff,   step_y_in;
   logic [DEC_W-1:0] decision_ff, decision_in;
   logic             active_ff,   active_in;

   logic                           accept;
   logic [RADIUS_W+SCALE_W-1:0]    scaled_prod;
   logic [X_W-1:0]                 radius_scaled;
   logic [DEC_W-1:0]               x_ext, y_ext, diff, dec_neg, dec_pos;
   logic [Y_W-1:0]                 y_minus1, y_dec, y_next;
   logic [X_W-1:0]                 x_next;
   logic                           done;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      scaled_prod   = {{SCALE_W{1'b0}}, req_data.radius} * {{RADIUS_W{1'b0}}, radius_scale};
      radius_scaled = scaled_prod[RADIUS_W+SCALE_W-1:SCALE_FRAC];

      x_ext   = {{(DEC_W-X_W){1'b0}}, step_x_ff};
      y_ext   = {{(DEC_W-Y_W){step_y_ff[Y_W-1]}}, step_y_ff};
      diff    = x_ext - y_ext;
      dec_neg = decision_ff + {x_ext[DEC_W-3:0], 2'b00} + DEC_W'(DEC_STEP_NEG);
      dec_pos = decision_ff + {diff[DEC_W-3:0], 2'b00} + DEC_W'(DEC_STEP_POS);

      // Decrement wraps within twelve bits, then sign-extends
      y_minus1 = step_y_ff - Y_W'(1);
      y_dec    = {y_minus1[X_W-1], y_minus1[X_W-1:0]};
      y_next   = decision_ff[DEC_W-1] ? step_y_ff : y_dec;
      x_next   = step_x_ff + X_W'(1);
      done     = $signed({1'b0, x_next}) > $signed(y_next);

      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      push        = 1'b0;

      if (accept) begin
         if (req_data.mode == MODE_START) begin
            step_x_in   = '0;
            step_y_in   = {1'b0, radius_scaled};
            decision_in = DEC_W'(DECISION_INIT) - {3'b000, radius_scaled, 1'b0};
            active_in   = 1'b1;
         end else if (active_ff) begin
            step_x_in   = x_next;
            step_y_in   = y_next;
            decision_in = decision_ff[DEC_W-1] ? dec_neg : dec_pos;
            active_in   = !done;
            push        = 1'b1;
         end
      end

      push_entry.step_x      = x_next;
      push_entry.step_y      = y_next;
      push_entry.circle_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff   <= '0;
         step_y_ff   <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         decision_ff <= decision_in;
         active_ff   <= active_in;
      end
   end

endmodule

[sv/mcpg_queue.sv]
// Short step queue between front and back end, held in registers.
// Depends on mcpg_pkg for the entry type.
module mcpg_queue
   import mcpg_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  step_entry_type push_entry,
   input  logic           pop,
   output step_entry_type head_entry,
   output logic           not_empty,
   output logic           full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   step_entry_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign head_entry = slot_ff[rd_ptr_ff];
   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("step queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("step queue read while empty");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("step queue fill count beyond its depth");
`endif

endmodule

[sv/mcpg_back.sv]
// Back end: scales the step offsets by the row aspect, walks the eight octant
// points and drives the response register. Depends on mcpg_pkg.
module mcpg_back
   import mcpg_pkg::*;
#(
   parameter int unsigned PLANE_MAX = PLANE_MAX_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SIZE_W-1:0]    plane_height,
   input  logic [SIZE_W-1:0]    plane_width,
   input  logic [ASPECT_W-1:0]  row_aspect,
   input  step_entry_type       head_entry,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 rsp_valid,
   output rsp_data_type         rsp_data,
   input  logic                 rsp_stall
);

   localparam int unsigned PLANE_W = $clog2(PLANE_MAX + 1);
   localparam int unsigned EXT_W   = (PLANE_W > SIZE_W) ? PLANE_W : SIZE_W;

   // Plane geometry, refreshed every cycle from the registers
   logic [SIZE_W-1:0] rows_ff, cols_ff, center_row_ff, center_col_ff;
   logic [SIZE_W-1:0] rows_in, cols_in, center_row_in, center_col_in;
   logic [EXT_W-1:0]  height_ext, width_ext;
   logic [2*SIZE_W-1:0] div3_prod;

   // Point sequencer
   logic                 seq_valid_ff, seq_valid_in;
   logic [IDX_W-1:0]     seq_idx_ff,   seq_idx_in;
   logic [X_W-1:0]       seq_x_ff;
   logic [Y_W-1:0]       seq_y_ff;
   logic [X_W-1:0]       seq_rx_ff;
   logic [ROFF_W-1:0]    seq_ry_ff;
   logic                 seq_done_ff;

   logic [X_W+ASPECT_W-1:0]        rx_prod;
   logic signed [Y_W+ASPECT_W:0]   ry_prod;

   logic                 emit;
   logic                 seq_finish;
   logic signed [CALC_W-1:0] row_off, col_val, row, col, row_base, col_base;
   logic                 on_plane;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_data_type         rsp_data_ff;

   always_comb begin
      height_ext    = EXT_W'(plane_height);
      width_ext     = EXT_W'(plane_width);
      rows_in       = SIZE_W'((height_ext > EXT_W'(PLANE_MAX)) ? EXT_W'(PLANE_MAX) : height_ext);
      cols_in       = SIZE_W'((width_ext > EXT_W'(PLANE_MAX)) ? EXT_W'(PLANE_MAX) : width_ext);
      div3_prod     = {{SIZE_W{1'b0}}, rows_in} * (2*SIZE_W)'(DIV3_MUL);
      center_row_in = SIZE_W'(div3_prod >> DIV3_SHIFT);
      center_col_in = cols_in >> 1;
   end

   always_ff @(posedge clock) begin
      rows_ff       <= rows_in;
      cols_ff       <= cols_in;
      center_row_ff <= center_row_in;
      center_col_ff <= center_col_in;
   end

   // Aspect products of the queue head; floor division by 256 is the bit select
   always_comb begin
      rx_prod = {{ASPECT_W{1'b0}}, head_entry.step_x} * {{X_W{1'b0}}, row_aspect};
      ry_prod = $signed({{(ASPECT_W+1){head_entry.step_y[Y_W-1]}}, head_entry.step_y})
              * $signed({{(Y_W+1){1'b0}}, row_aspect});
   end

   assign emit       = seq_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign seq_finish = emit && (seq_idx_ff == LAST_IDX);
   assign pop        = head_valid && (!seq_valid_ff || seq_finish);

   always_comb begin
      seq_valid_in = seq_valid_ff;
      seq_idx_in   = seq_idx_ff;
      if (emit) begin
         seq_idx_in = seq_idx_ff + IDX_W'(1);
      end
      if (pop) begin
         seq_valid_in = 1'b1;
         seq_idx_in   = '0;
      end else if (seq_finish) begin
         seq_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= 1'b0;
         seq_idx_ff   <= '0;
      end else begin
         seq_valid_ff <= seq_valid_in;
         seq_idx_ff   <= seq_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         seq_x_ff    <= head_entry.step_x;
         seq_y_ff    <= head_entry.step_y;
         seq_done_ff <= head_entry.circle_done;
         seq_rx_ff   <= rx_prod[X_W+ASPECT_W-1:ASPECT_FRAC];
         seq_ry_ff   <= ry_prod[ROFF_W+ASPECT_FRAC-1:ASPECT_FRAC];
      end
   end

   // Index bit 2 picks the (x offset, y column) or (y offset, x column) pair,
   // bit 0 negates the row offset and bit 1 negates the column term.
   always_comb begin
      row_off  = seq_idx_ff[2] ? CALC_W'($signed(seq_ry_ff))
                               : $signed(CALC_W'(seq_rx_ff));
      col_val  = seq_idx_ff[2] ? $signed(CALC_W'(seq_x_ff))
                               : CALC_W'($signed(seq_y_ff));
      row_base = $signed(CALC_W'(center_row_ff));
      col_base = $signed(CALC_W'(center_col_ff));
      row      = seq_idx_ff[0] ? row_base - row_off : row_base + row_off;
      col      = seq_idx_ff[1] ? col_base - col_val : col_base + col_val;
      on_plane = !row[CALC_W-1] && (row < $signed(CALC_W'(rows_ff)))
              && !col[CALC_W-1] && (col < $signed(CALC_W'(cols_ff)));
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.point_row   <= row[COORD_W-1:0];
         rsp_data_ff.point_col   <= col[COORD_W-1:0];
         rsp_data_ff.on_plane    <= on_plane;
         rsp_data_ff.last_point  <= (seq_idx_ff == LAST_IDX);
         rsp_data_ff.circle_done <= seq_done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pop_only_between_steps: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!seq_valid_ff || seq_idx_ff == LAST_IDX))
      else $error("new step taken while points of the previous step remain");

   a_last_flag_from_index: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_data_ff.last_point == ($past(seq_idx_ff) == LAST_IDX)))
      else $error("last_point does not match the eighth octant point");

   a_idle_index_cleared: assert property (@(posedge clock) disable iff (reset)
      !seq_valid_ff |-> (seq_idx_ff == '0))
      else $error("point index left mid-step while sequencer idle");
`endif

endmodule

[sv/midpoint_circle_point_generator.sv]
// Top level of the midpoint circle point generator: configuration registers,
// front end, step queue and back end. Depends on mcpg_pkg and all mcpg_ modules.
//
// A start transaction (mode 0) loads a radius, scales it by radius_scale (Q4.4)
// and resets the midpoint recurrence; it produces no response. Each advance
// transaction (mode 1) steps the recurrence and produces eight response
// transactions, the octant points around row height/3 and column width/2,
// with row offsets scaled by row_aspect (Q0.8); the eighth carries last_point,
// and all eight carry circle_done on the step that ends the circle. An advance
// while no circle is active is absorbed silently. The back end emits one point
// per cycle while the response channel is not stalled, paced by the single
// response register that the point sequencer fills. The front end updates the
// recurrence in the cycle a transaction is accepted and queues the step; the
// queue (QUEUE_DEPTH steps) lets requests run ahead of a stalled response
// channel, and req_stall rises only when it is full. When the back end is idle,
// the first point of an advance passes through the step queue, the sequencer
// registers and the response register. Configuration writes take effect at
// once; write only while no transaction is in flight.
module midpoint_circle_point_generator
   import mcpg_pkg::*;
#(
   parameter int unsigned PLANE_MAX   = PLANE_MAX_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_data_type          req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output rsp_data_type          rsp_data,
   input  logic                  rsp_stall,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // Configuration registers, all cleared to their documented defaults.
   logic [SIZE_W-1:0]   plane_height_ff, plane_height_in;
   logic [SIZE_W-1:0]   plane_width_ff,  plane_width_in;
   logic [SCALE_W-1:0]  radius_scale_ff, radius_scale_in;
   logic [ASPECT_W-1:0] row_aspect_ff,   row_aspect_in;

   // Front to queue and queue to back.
   logic           push;
   step_entry_type push_entry;
   logic           pop;
   step_entry_type head_entry;
   logic           head_valid;
   logic           queue_full;

   always_comb begin
      plane_height_in = plane_height_ff;
      plane_width_in  = plane_width_ff;
      radius_scale_in = radius_scale_ff;
      row_aspect_in   = row_aspect_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PLANE_HEIGHT: plane_height_in = csr_wdata[SIZE_W-1:0];
            CSR_PLANE_WIDTH:  plane_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_RADIUS_SCALE: radius_scale_in = csr_wdata[SCALE_W-1:0];
            CSR_ROW_ASPECT:   row_aspect_in   = csr_wdata[ASPECT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_height_ff <= HEIGHT_RESET;
         plane_width_ff  <= WIDTH_RESET;
         radius_scale_ff <= SCALE_RESET;
         row_aspect_ff   <= ASPECT_RESET;
      end else begin
         plane_height_ff <= plane_height_in;
         plane_width_ff  <= plane_width_in;
         radius_scale_ff <= radius_scale_in;
         row_aspect_ff   <= row_aspect_in;
      end
   end

   // The front end owns the recurrence state and pushes one entry per advance taken while a circle is active.
   mcpg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .radius_scale (radius_scale_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   mcpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (head_valid),
      .full       (queue_full)
   );

   // The back end turns each queued step into eight response transactions.
   mcpg_back #(
      .PLANE_MAX (PLANE_MAX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .plane_height (plane_height_ff),
      .plane_width  (plane_width_ff),
      .row_aspect   (row_aspect_ff),
      .head_entry   (head_entry),
      .head_valid   (head_valid),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall)
   );

endmodule

[sim/midpoint_circle_point_generator_tb.sv]
// Self-checking testbench for the midpoint circle point generator.
// Depends on mcpg_pkg and the midpoint_circle_point_generator top level only.
`timescale 1ns / 1ps

module midpoint_circle_point_generator_tb;
   import mcpg_pkg::*;

   // Effective transactions offered per register setting in the random part.
   localparam int ITEMS_PER_SETTING = 30;
   // Ample settling time after a drain: the step queue holds four steps, and the
   // first point of an advance passes the queue, sequencer and response register.
   localparam int DRAIN_CYCLES      = 16;
   // The receiver's long hold-off, and the window of transactions with no idling.
   localparam int HOLD_AT           = 150;
   localparam int HOLD_CYCLES       = 300;
   localparam int QUIET_FROM        = 250;
   localparam int QUIET_TO          = 330;

   // State of one circle walk: the midpoint recurrence and whether a circle is open.
   typedef struct {
      int x;
      int y;
      int d;
      bit active;
   } circle_walk_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   req_data_type       req_data = '0;
   logic               req_stall;
   logic               rsp_valid;
   rsp_data_type       rsp_data;
   logic               rsp_stall = 1'b0;
   logic               csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   // Our copy of the configuration registers, starting from their reset values.
   logic [SIZE_W-1:0]   cfg_height = HEIGHT_RESET;
   logic [SIZE_W-1:0]   cfg_width  = WIDTH_RESET;
   logic [SCALE_W-1:0]  cfg_scale  = SCALE_RESET;
   logic [ASPECT_W-1:0] cfg_aspect = ASPECT_RESET;

   // The predictor's walk follows accepted transactions; the planner's walk follows
   // the backlog as it is filled, so that sequences can be shaped to end circles.
   circle_walk_type predicted_walk = '{x: 0, y: 0, d: 0, active: 1'b0};
   circle_walk_type planned_walk   = '{x: 0, y: 0, d: 0, active: 1'b0};

   req_data_type req_backlog[$];
   rsp_data_type expected_points[$];

   int accepted_items = 0;
   int planned_items = 0;
   int circle_starts = 0;
   int drawing_steps = 0;
   int ignored_advances = 0;
   int circles_finished = 0;
   int points_checked = 0;
   int settings_applied = 0;
   int failures = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic quiet_stretch;

   assign quiet_stretch = accepted_items >= QUIET_FROM && accepted_items < QUIET_TO;

   midpoint_circle_point_generator dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A start scales the radius by the Q4.4 factor (truncating) and opens the walk
   // at the top of the circle, with the decision term kept to sixteen bits.
   function automatic circle_walk_type circle_begin(logic [RADIUS_W-1:0] radius,
                                                    logic [SCALE_W-1:0] scale);
      circle_walk_type w;
      int r;
      r = (int'(radius) * int'(scale)) >>> SCALE_FRAC;
      w.x = 0;
      w.y = r;
      w.d = shortint'(int'(DECISION_INIT) - 2 * r);
      w.active = 1'b1;
      return w;
   endfunction

   // One midpoint step, using the old x and y to update the decision term. The
   // y coordinate wraps within twelve bits when it falls, which is what ends
   // the very large circles early; the walk closes once x has passed y.
   function automatic circle_walk_type circle_advance(circle_walk_type w);
      circle_walk_type n;
      logic signed [11:0] fallen_y;
      n = w;
      if (w.d < 0) begin
         n.d = shortint'(w.d + 4 * w.x + int'(DEC_STEP_NEG));
      end else begin
         n.d = shortint'(w.d + 4 * (w.x - w.y) + int'(DEC_STEP_POS));
         fallen_y = 12'(w.y - 1);
         n.y = fallen_y;
      end
      n.x = (w.x + 1) % 4096;
      n.active = n.x <= n.y;
      return n;
   endfunction

   // Driver. The predictor runs here, at the edge where a transaction is accepted,
   // so it always sees the configuration that the block sees.
   always @(posedge clock) begin : driver
      int h, w, cr, cc, rx, ry, off, span, row, col;
      rsp_data_type pt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.mode == MODE_START) begin
               predicted_walk = circle_begin(req_data.radius, cfg_scale);
               circle_starts++;
            end else if (predicted_walk.active) begin
               predicted_walk = circle_advance(predicted_walk);
               // Oversized planes are treated as PLANE_MAX wide and high.
               h = (cfg_height > PLANE_MAX_DEF) ? PLANE_MAX_DEF : cfg_height;
               w = (cfg_width > PLANE_MAX_DEF) ? PLANE_MAX_DEF : cfg_width;
               cr = h / 3;
               cc = w / 2;
               rx = (predicted_walk.x * int'(cfg_aspect)) >>> ASPECT_FRAC;
               ry = (predicted_walk.y * int'(cfg_aspect)) >>> ASPECT_FRAC;
               // The first four points use the aspect-scaled x as row offset and y
               // as column offset, the last four swap the roles. Bit 0 of the
               // point number mirrors the row, bit 1 mirrors the column.
               for (int k = 0; k < 8; k++) begin
                  off  = (k < 4) ? rx : ry;
                  span = (k < 4) ? predicted_walk.y : predicted_walk.x;
                  row  = k[0] ? cr - off : cr + off;
                  col  = k[1] ? cc - span : cc + span;
                  pt.point_row   = row[COORD_W-1:0];
                  pt.point_col   = col[COORD_W-1:0];
                  pt.on_plane    = row >= 0 && row < h && col >= 0 && col < w;
                  pt.last_point  = (k == 7);
                  pt.circle_done = !predicted_walk.active;
                  expected_points.push_back(pt);
               end
               drawing_steps++;
               if (!predicted_walk.active) circles_finished++;
            end else begin
               ignored_advances++;
            end
            accepted_items <= accepted_items + 1;
         end
         // A new transaction is offered only once the previous one has gone; a
         // stalled payload is left exactly as it is.
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 20)) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure. Once, part-way through the run, it holds off for a
   // long stretch so that the step queue fills and the block stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_items >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_stretch && $urandom_range(0, 99) < 20;
      end
   end

   // Monitor: every accepted response transaction is compared with the oldest
   // outstanding expectation, field by field.
   always @(posedge clock) begin : monitor
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected point: row %0d col %0d on %0b last %0b done %0b",
                        $signed(rsp_data.point_row), $signed(rsp_data.point_col),
                        rsp_data.on_plane, rsp_data.last_point, rsp_data.circle_done);
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.point_row !== want.point_row || rsp_data.point_col !== want.point_col
                || rsp_data.on_plane !== want.on_plane
                || rsp_data.last_point !== want.last_point
                || rsp_data.circle_done !== want.circle_done) begin
               failures++;
               if (failures <= 10) begin
                  $display("Point %0d differs: expected row %0d col %0d on %0b last %0b done %0b,",
                           points_checked, $signed(want.point_row), $signed(want.point_col),
                           want.on_plane, want.last_point, want.circle_done);
                  $display("   got row %0d col %0d on %0b last %0b done %0b",
                           $signed(rsp_data.point_row), $signed(rsp_data.point_col),
                           rsp_data.on_plane, rsp_data.last_point, rsp_data.circle_done);
               end
            end
            points_checked++;
         end
      end
   end

   // Adds one transaction to the backlog and follows it with the planner's walk.
   // Advances that would find no open circle are not counted towards the total.
   task automatic queue_item(mode_type mode, logic [RADIUS_W-1:0] radius);
      req_data_type item;
      item.mode = mode;
      item.radius = radius;
      if (mode == MODE_START) begin
         planned_walk = circle_begin(radius, cfg_scale);
         planned_items++;
      end else if (planned_walk.active) begin
         planned_walk = circle_advance(planned_walk);
         planned_items++;
      end
      req_backlog.push_back(item);
   endtask

   // A start followed by advances until the circle closes or the cap is reached;
   // a low cap leaves a broken sequence for the next start to cut short. The
   // radius field of an advance carries random bits that the block must ignore.
   task automatic draw_circle(logic [RADIUS_W-1:0] radius, int cap);
      int n;
      n = 0;
      queue_item(MODE_START, radius);
      while (planned_walk.active && n < cap) begin
         queue_item(MODE_ADVANCE, RADIUS_W'($urandom_range(0, 255)));
         n++;
      end
      if ($urandom_range(0, 3) == 0) queue_item(MODE_ADVANCE, RADIUS_W'($urandom_range(0, 255)));
   endtask

   // Waits until every transaction has been accepted and every point has come
   // back, then lets the block settle, since starts and ignored advances leave
   // no trace on the response side. Sampled on the falling edge so that the
   // checks see the state after the rising edge has fully resolved.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || expected_points.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(logic [SIZE_W-1:0] height, logic [SIZE_W-1:0] width,
                                logic [SCALE_W-1:0] scale, logic [ASPECT_W-1:0] aspect);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PLANE_HEIGHT;
      csr_wdata    <= CSR_W'(height);
      @(posedge clock);
      csr_index    <= CSR_PLANE_WIDTH;
      csr_wdata    <= CSR_W'(width);
      @(posedge clock);
      csr_index    <= CSR_RADIUS_SCALE;
      csr_wdata    <= CSR_W'(scale);
      @(posedge clock);
      csr_index    <= CSR_ROW_ASPECT;
      csr_wdata    <= CSR_W'(aspect);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_height = height;
      cfg_width  = width;
      cfg_scale  = scale;
      cfg_aspect = aspect;
      settings_applied++;
   endtask

   initial begin : stimulus
      int roll;
      int goal;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, on the reset configuration. An advance with no circle open
      // must be absorbed, as must one just after a circle has closed.
      queue_item(MODE_ADVANCE, 8'hFF);
      // Zero radius: a single step drops y below zero and closes the circle.
      draw_circle(8'd0, 60);
      queue_item(MODE_ADVANCE, 8'h00);
      draw_circle(8'd1, 60);
      draw_circle(8'd5, 60);
      // Largest radius, cut short and then restarted twice in a row.
      draw_circle(8'd255, 4);
      queue_item(MODE_START, 8'hAA);
      draw_circle(8'd2, 60);

      // Random part, over a series of register settings with the extremes first.
      for (int setting = 0; setting < 7; setting++) begin
         wait_for_drain();
         case (setting)
            0: apply_setting(10'd1023, 10'd1023, 8'd255, 8'd255);
            1: apply_setting(10'd1, 10'd1, 8'd0, 8'd0);
            2: apply_setting(10'd0, 10'd0, SCALE_RESET, ASPECT_RESET);
            3: apply_setting(10'd512, 10'd513, 8'd32, 8'd100);
            4, 5: apply_setting(SIZE_W'($urandom_range(0, 1023)),
                                SIZE_W'($urandom_range(0, 1023)),
                                SCALE_W'($urandom_range(0, 255)),
                                ASPECT_W'($urandom_range(0, 255)));
            default: apply_setting(HEIGHT_RESET, WIDTH_RESET, SCALE_RESET, ASPECT_RESET);
         endcase
         // At full scale the largest radius overflows the y coordinate on its
         // first fall, so this circle is drawn to its end once.
         if (setting == 0) draw_circle(8'd255, 100);
         goal = planned_items + ITEMS_PER_SETTING;
         while (planned_items < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               queue_item($urandom_range(0, 1) ? MODE_ADVANCE : MODE_START,
                          RADIUS_W'($urandom_range(0, 255)));
            end else begin
               draw_circle(RADIUS_W'((roll < 70) ? $urandom_range(0, 24)
                                                 : $urandom_range(0, 255)),
                           (roll < 85) ? 60 : $urandom_range(1, 6));
            end
         end
      end

      wait_for_drain();
      $display("Covered %0d transactions over %0d register settings: %0d starts, %0d steps,",
               accepted_items, settings_applied + 1, circle_starts, drawing_steps);
      $display("%0d idle advances, %0d circles closed and %0d points compared.",
               ignored_advances, circles_finished, points_checked);
      if (failures == 0 && expected_points.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Guard against a block that hangs; the correct run is a small fraction of this.
   initial begin
      #2000000;
      $display("Timed out with %0d points outstanding.", expected_points.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
